/* rtl/kway_heap_merge_defines.svh */
// Assertion macros used by the heap merge datapath.
// Expects clk and rst_n in the scope of each use.
`ifndef KWAY_HEAP_MERGE_DEFINES_SVH
`define KWAY_HEAP_MERGE_DEFINES_SVH
`ifndef SYNTH
`define KWHM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kway_heap_merge: assertion failed");
`define KWHM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kway_heap_merge: assertion failed");
`else
`define KWHM_ASSERT_IMP(lbl, ante, cons)
`define KWHM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/kwhm_pkg.sv */
// Types, constants and the entry order of the heap merge.
// No dependencies.
`timescale 1ns / 1ps
package kwhm_pkg;
  localparam int VALUE_W = 64;
  localparam int RUN_IDX_W = 4;
  localparam int CFG_W = 5;
  localparam int DEF_NUM_WAYS = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

  typedef enum logic [2:0] {
    S_IDLE, S_BRD, S_BLD, S_RDL, S_RDR, S_CMP, S_ERD, S_EMIT
  } kwhm_state_t;

  typedef enum logic [1:0] {
    RD_BUILD, RD_LEFT, RD_RIGHT, RD_ROOT
  } kwhm_rd_sel_t;

  typedef struct packed {
    logic         fill_wr;
    logic         merge_ld;
    logic         rd_en;
    kwhm_rd_sel_t rd_sel;
    logic         hold_ld;
    logic         save_left;
    logic         step;
    logic         wr_hold;
    logic         build_dec;
    logic         emit;
  } kwhm_cmd_t;

  typedef struct packed {
    logic merging;
    logic fill_last;
    logic l_ok;
    logic r_ok;
    logic child_win;
    logic build_more;
    logic out_free;
  } kwhm_sts_t;

  function automatic logic entry_less(input logic a_ex,
                                      input logic signed [VALUE_W-1:0] a_key,
                                      input logic b_ex,
                                      input logic signed [VALUE_W-1:0] b_key);
    entry_less = !a_ex && (b_ex || (a_key < b_key));
  endfunction
endpackage

/* rtl/kwhm_dp.sv */
// Datapath of the heap merge: heap memory, sift registers, output register.
// Depends on kwhm_pkg and kway_heap_merge_defines.svh.
`timescale 1ns / 1ps
`include "kway_heap_merge_defines.svh"
module kwhm_dp import kwhm_pkg::*; #(
  parameter int NUM_WAYS = DEF_NUM_WAYS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kwhm_cmd_t                   cmd,
  output kwhm_sts_t                   sts,
  input  logic signed [VALUE_W-1:0]   in_value,
  input  logic                        in_run_empty,
  input  logic                        cfg_we,
  input  logic [CFG_W-1:0]            cfg_num_ways,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VALUE_W-1:0]   out_min_value,
  output logic [RUN_IDX_W-1:0]        out_run_index,
  output logic                        out_all_done
);
  localparam int AW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int CW = $clog2(NUM_WAYS + 1);
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;
  localparam int IW = AW + 2;

  logic signed [VALUE_W-1:0] mem_key [NUM_WAYS];
  logic                      mem_ex  [NUM_WAYS];
  logic [AW-1:0]             mem_src [NUM_WAYS];

  logic [CFG_W-1:0]          num_ways_r;
  logic [CW-1:0]             fill_cnt_r;
  logic [CW-1:0]             len_r;
  logic                      merging_r;
  logic [AW-1:0]             build_i_r;
  logic [AW-1:0]             pos_r;
  logic [AW-1:0]             root_src_r;
  logic signed [VALUE_W-1:0] hold_key_r;
  logic                      hold_ex_r;
  logic [AW-1:0]             hold_src_r;
  logic signed [VALUE_W-1:0] left_key_r;
  logic                      left_ex_r;
  logic [AW-1:0]             left_src_r;
  logic                      left_win_r;
  logic signed [VALUE_W-1:0] rd_key_r;
  logic                      rd_ex_r;
  logic [AW-1:0]             rd_src_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_min_r;
  logic [RUN_IDX_W-1:0]      out_idx_r;
  logic                      out_done_r;

  logic [XW-1:0]             ways;
  logic [AW-1:0]             slot;
  logic [CW-1:0]             slot_inc;
  logic [IW-1:0]             l_idx;
  logic [IW-1:0]             r_idx;
  logic                      right_win;
  logic signed [VALUE_W-1:0] cand_key;
  logic                      cand_ex;
  logic [AW-1:0]             raddr;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wkey;
  logic                      wex;
  logic [AW-1:0]             wsrc;

  always_comb begin
    if (num_ways_r == '0) begin
      ways = XW'(1);
    end else if (XW'(num_ways_r) > XW'(NUM_WAYS)) begin
      ways = XW'(NUM_WAYS);
    end else begin
      ways = XW'(num_ways_r);
    end
    slot      = (fill_cnt_r >= CW'(NUM_WAYS)) ? '0 : fill_cnt_r[AW-1:0];
    slot_inc  = CW'(slot) + CW'(1);
    l_idx     = IW'({pos_r, 1'b1});
    r_idx     = IW'({pos_r, 1'b0}) + IW'(2);
    cand_key  = left_win_r ? left_key_r : hold_key_r;
    cand_ex   = left_win_r ? left_ex_r : hold_ex_r;

    sts.merging    = merging_r;
    sts.fill_last  = XW'(slot_inc) >= ways;
    sts.l_ok       = l_idx < IW'(len_r);
    sts.r_ok       = r_idx < IW'(len_r);
    right_win      = sts.r_ok && entry_less(rd_ex_r, rd_key_r, cand_ex, cand_key);
    sts.child_win  = right_win || left_win_r;
    sts.build_more = build_i_r != '0;
    sts.out_free   = !out_valid_r || out_ready;

    unique case (cmd.rd_sel)
      RD_BUILD: raddr = build_i_r;
      RD_LEFT:  raddr = l_idx[AW-1:0];
      RD_RIGHT: raddr = r_idx[AW-1:0];
      RD_ROOT:  raddr = '0;
    endcase

    we    = cmd.fill_wr || cmd.step || cmd.wr_hold;
    waddr = pos_r;
    wkey  = hold_key_r;
    wex   = hold_ex_r;
    wsrc  = hold_src_r;
    if (cmd.fill_wr) begin
      waddr = slot;
      wkey  = in_value;
      wex   = in_run_empty;
      wsrc  = slot;
    end else if (cmd.step) begin
      wkey = right_win ? rd_key_r : left_key_r;
      wex  = right_win ? rd_ex_r : left_ex_r;
      wsrc = right_win ? rd_src_r : left_src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_key[waddr] <= wkey;
      mem_ex[waddr]  <= wex;
      mem_src[waddr] <= wsrc;
    end
    if (cmd.rd_en) begin
      rd_key_r <= mem_key[raddr];
      rd_ex_r  <= mem_ex[raddr];
      rd_src_r <= mem_src[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ways_r  <= CFG_RESET;
      fill_cnt_r  <= '0;
      len_r       <= '0;
      merging_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_ways_r <= cfg_num_ways;
      end
      if (cmd.fill_wr) begin
        fill_cnt_r <= slot_inc;
        if (sts.fill_last) begin
          len_r <= slot_inc;
        end
      end
      if (cmd.emit) begin
        merging_r   <= !rd_ex_r;
        out_valid_r <= 1'b1;
        if (rd_ex_r) begin
          fill_cnt_r <= '0;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      build_i_r <= slot >> 1;
    end else if (cmd.build_dec) begin
      build_i_r <= build_i_r - AW'(1);
    end
    if (cmd.merge_ld) begin
      hold_key_r <= in_value;
      hold_ex_r  <= in_run_empty;
      hold_src_r <= root_src_r;
      pos_r      <= '0;
    end else if (cmd.hold_ld) begin
      hold_key_r <= rd_key_r;
      hold_ex_r  <= rd_ex_r;
      hold_src_r <= rd_src_r;
      pos_r      <= build_i_r;
    end else if (cmd.step) begin
      pos_r <= right_win ? r_idx[AW-1:0] : l_idx[AW-1:0];
    end
    if (cmd.save_left) begin
      left_key_r <= rd_key_r;
      left_ex_r  <= rd_ex_r;
      left_src_r <= rd_src_r;
      left_win_r <= entry_less(rd_ex_r, rd_key_r, hold_ex_r, hold_key_r);
    end
    if (cmd.emit) begin
      root_src_r <= rd_src_r;
      out_min_r  <= rd_ex_r ? '0 : rd_key_r;
      out_idx_r  <= rd_ex_r ? '0 : RUN_IDX_W'(rd_src_r);
      out_done_r <= rd_ex_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_min_value = out_min_r;
  assign out_run_index = out_idx_r;
  assign out_all_done  = out_done_r;

  `KWHM_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
  `KWHM_ASSERT_IMP(a_fill_phase, cmd.fill_wr || cmd.merge_ld, merging_r == cmd.merge_ld)
  `KWHM_ASSERT_IMP(a_left_in_heap, cmd.rd_en && (cmd.rd_sel == RD_LEFT), sts.l_ok)
  `KWHM_ASSERT_IMP(a_step_wins, cmd.step, sts.child_win)
  `KWHM_ASSERT_NXT(a_len_set, cmd.fill_wr && sts.fill_last,
                   (len_r != '0) && (len_r <= CW'(NUM_WAYS)))
endmodule

/* rtl/kwhm_ctrl.sv */
// Sequencer of the heap merge: fill, heap build, sift-down and emit steps.
// Depends on kwhm_pkg.
`timescale 1ns / 1ps
module kwhm_ctrl import kwhm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kwhm_sts_t sts,
  output kwhm_cmd_t cmd
);
  kwhm_state_t state_r;
  kwhm_state_t state_nxt;
  logic        in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_BUILD;
    in_ready  = (state_r == S_IDLE);
    in_fire   = in_valid && in_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (sts.merging) begin
            cmd.merge_ld = 1'b1;
            state_nxt    = S_RDL;
          end else begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) begin
              state_nxt = S_BRD;
            end
          end
        end
      end
      S_BRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BUILD;
        state_nxt  = S_BLD;
      end
      S_BLD: begin
        cmd.hold_ld = 1'b1;
        state_nxt   = S_RDL;
      end
      S_RDL: begin
        if (sts.l_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_RDR;
        end else begin
          cmd.wr_hold = 1'b1;
        end
      end
      S_RDR: begin
        cmd.save_left = 1'b1;
        cmd.rd_en     = sts.r_ok;
        cmd.rd_sel    = RD_RIGHT;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        if (sts.child_win) begin
          cmd.step  = 1'b1;
          state_nxt = S_RDL;
        end else begin
          cmd.wr_hold = 1'b1;
        end
      end
      S_ERD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ROOT;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
    if (cmd.wr_hold) begin
      if (!sts.merging && sts.build_more) begin
        cmd.build_dec = 1'b1;
        state_nxt     = S_BRD;
      end else begin
        state_nxt = S_ERD;
      end
    end
  end
endmodule

/* rtl/kway_heap_merge.sv */
// K-way merge of sorted runs through a binary min-heap held in one memory.
// Fill takes one head per cycle; the last starts the build, a sift-down of each parent,
// then the root is read and emitted. Merge: an accepted head replaces the root and is
// sifted down, children read in turn; no new head is taken until the minimum is emitted.
// Synchronous active-low reset: fill phase, zero heads, num_ways 2, heap contents unset.
// Depends on kwhm_pkg, kwhm_ctrl and kwhm_dp.
`timescale 1ns / 1ps
module kway_heap_merge import kwhm_pkg::*; #(
  parameter int NUM_WAYS = DEF_NUM_WAYS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_run_empty,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_min_value,
  output logic [RUN_IDX_W-1:0]      out_run_index,
  output logic                      out_all_done,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_num_ways
);
  kwhm_cmd_t cmd;
  kwhm_sts_t sts;

  assign cfg_ready = 1'b1;

  kwhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kwhm_dp #(
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .in_run_empty  (in_run_empty),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_num_ways  (cfg_num_ways),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_min_value (out_min_value),
    .out_run_index (out_run_index),
    .out_all_done  (out_all_done)
  );
endmodule
